### design/bpa_pkg.sv
// Shared constants and types for the bitmap page allocator.
package bpa_pkg;

    localparam int NUM_PAGES = 4096;
    localparam int PAGE_W    = 12;             // page index width
    localparam int CNT_W     = PAGE_W + 1;     // page bound width, holds NUM_PAGES itself
    localparam int WORD_BITS = 64;             // pages per bitmap row
    localparam int BIT_W     = 6;              // bit index inside a row
    localparam int ROWS      = NUM_PAGES / WORD_BITS;
    localparam int ROW_W     = PAGE_W - BIT_W;
    localparam int GROUP_BITS = 8;             // bits examined per scan step
    localparam int GROUPS    = WORD_BITS / GROUP_BITS;
    localparam int GROUP_W   = 3;
    localparam int SUB_W     = 3;

    localparam logic [CNT_W-1:0] PAGE_LIMIT = CNT_W'(NUM_PAGES);

    typedef enum logic [1:0] {
        CMD_MARK  = 2'd0,
        CMD_ALLOC = 2'd1,
        CMD_FREE  = 2'd2
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_WR,
        S_FIND_ROW,
        S_ARD,
        S_ASTART,
        S_AFIND,
        S_AWR,
        S_DONE
    } state_t;

    typedef struct packed {
        logic             done;
        logic [BIT_W-1:0] index;
    } ffs_status_t;

endpackage

### design/bpa_ffs.sv
// Iterative lowest-set-bit finder, one byte of the word per cycle.
module bpa_ffs (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [bpa_pkg::WORD_BITS-1:0]   word,
    output bpa_pkg::ffs_status_t            status
);

    logic [bpa_pkg::WORD_BITS-1:0]  word_reg;
    logic [bpa_pkg::GROUP_W-1:0]    group_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [bpa_pkg::BIT_W-1:0]      index_reg;

    logic [bpa_pkg::GROUP_BITS-1:0] slice;
    logic [bpa_pkg::SUB_W-1:0]      sub_bit;

    assign slice = word_reg[group_reg*bpa_pkg::GROUP_BITS +: bpa_pkg::GROUP_BITS];

    always_comb
    begin
        sub_bit = '0;
        for (int j = bpa_pkg::GROUP_BITS - 1; j >= 0; j--)
        begin
            if (slice[j])
            begin
                sub_bit = bpa_pkg::SUB_W'(j);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            group_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                group_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (slice != '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    group_reg <= group_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            word_reg <= word;
        end
        if (busy_reg && !start && slice != '0)
        begin
            index_reg <= {group_reg, sub_bit};
        end
    end

    assign status.done  = done_reg;
    assign status.index = index_reg;

endmodule

### design/bitmap_page_allocator_top.sv
// Top level of the bitmap page allocator: command sequencer and page bitmap.
//
// The bitmap lives in a 64-row by 64-bit memory, one row per 64 pages, with a
// per-row valid flag and a per-row "any free" flag in flip-flops; reset clears
// the flags at once, so there is no clearing pass and the block is ready right
// after reset. One command is worked at a time. Mark reads and writes each
// bitmap row the range touches (one read, one write per row), free does the
// same for its single row, an empty range, an unused code and an allocate
// that finds nothing go straight to the result, and a successful allocate
// has the shared byte-wide scanner search the row flags and then the
// chosen row, up to 8 steps each. A new command is accepted while the last
// result still waits on the master side; a second finished result holds the
// block until that one is taken.
module bitmap_page_allocator_top (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration: reserved_below_page
    input  logic                            cfg_we,
    input  logic [bpa_pkg::CNT_W-1:0]       cfg_wdata,
    // command stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,   // command[1:0], first_page[13:2], end_page[26:14]
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [15:0]                     m_tdata    // page_index[11:0], found[12]
);

    bpa_pkg::state_t                state_reg, state_next;
    logic [bpa_pkg::CNT_W-1:0]      reserved_reg;
    logic [bpa_pkg::CNT_W-1:0]      lo_reg, lo_next;
    logic [bpa_pkg::CNT_W-1:0]      hi_reg, hi_next;
    logic [bpa_pkg::ROW_W-1:0]      row_reg, row_next;
    logic [bpa_pkg::ROW_W-1:0]      last_row_reg, last_row_next;
    logic [bpa_pkg::BIT_W-1:0]      bit_reg, bit_next;
    logic [bpa_pkg::PAGE_W-1:0]     res_index_reg, res_index_next;
    logic                           res_found_reg, res_found_next;
    logic [bpa_pkg::ROWS-1:0]       valid_reg;
    logic [bpa_pkg::ROWS-1:0]       summary_reg;
    logic [bpa_pkg::WORD_BITS-1:0]  rdata_reg;
    logic                           out_valid_reg, out_valid_next;
    logic [15:0]                    out_data_reg, out_data_next;

    logic [bpa_pkg::WORD_BITS-1:0]  bitmap_mem [bpa_pkg::ROWS];

    logic                           rd_en, wr_en;
    logic [bpa_pkg::WORD_BITS-1:0]  wr_data;
    logic                           ffs_start;
    logic [bpa_pkg::WORD_BITS-1:0]  ffs_word;
    bpa_pkg::ffs_status_t           ffs_st;

    logic [1:0]                     in_cmd;
    logic [bpa_pkg::CNT_W-1:0]      in_first;
    logic [bpa_pkg::CNT_W-1:0]      in_end;
    logic [bpa_pkg::CNT_W-1:0]      mark_lo, mark_hi, last_page;
    logic [bpa_pkg::WORD_BITS-1:0]  range_mask;
    logic [bpa_pkg::WORD_BITS-1:0]  row_word;
    logic [bpa_pkg::WORD_BITS-1:0]  bit_mask;

    assign in_cmd   = s_tdata[1:0];
    assign in_first = {1'b0, s_tdata[13:2]};
    assign in_end   = s_tdata[26:14];

    assign mark_lo   = (in_first >= reserved_reg) ? in_first : reserved_reg;
    assign mark_hi   = (in_end > bpa_pkg::PAGE_LIMIT) ? bpa_pkg::PAGE_LIMIT : in_end;

    // pages of the current row that fall inside [lo, hi)
    always_comb
    begin
        logic [bpa_pkg::CNT_W-1:0] page;
        for (int j = 0; j < bpa_pkg::WORD_BITS; j++)
        begin
            page = {1'b0, row_reg, bpa_pkg::BIT_W'(j)};
            range_mask[j] = (page >= lo_reg) && (page < hi_reg);
        end
    end

    // a row never written reads as all taken
    assign row_word = valid_reg[row_reg] ? rdata_reg : '0;
    assign bit_mask = bpa_pkg::WORD_BITS'(1) << bit_reg;

    bpa_ffs u_ffs (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (ffs_start),
        .word   (ffs_word),
        .status (ffs_st)
    );

    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        row_next       = row_reg;
        last_row_next  = last_row_reg;
        last_page      = '0;
        bit_next       = bit_reg;
        res_index_next = res_index_reg;
        res_found_next = res_found_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        s_tready       = 1'b0;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        wr_data        = row_word | range_mask;
        ffs_start      = 1'b0;
        ffs_word       = summary_reg;

        unique case (state_reg)
            bpa_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    res_index_next = '0;
                    res_found_next = 1'b0;
                    state_next     = bpa_pkg::S_DONE;
                    case (in_cmd) inside
                        bpa_pkg::CMD_MARK, bpa_pkg::CMD_FREE:
                        begin
                            // free is a one-page mark without the reserved limit
                            if (in_cmd == bpa_pkg::CMD_MARK)
                            begin
                                lo_next = mark_lo;
                                hi_next = mark_hi;
                            end
                            else
                            begin
                                lo_next = in_first;
                                hi_next = in_first + 1'b1;
                            end
                            last_page     = hi_next - 1'b1;
                            row_next      = lo_next[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                            last_row_next = last_page[bpa_pkg::PAGE_W-1:bpa_pkg::BIT_W];
                            if (lo_next < hi_next)
                            begin
                                state_next = bpa_pkg::S_RD;
                            end
                        end
                        bpa_pkg::CMD_ALLOC:
                        begin
                            if (summary_reg != '0)
                            begin
                                ffs_start  = 1'b1;
                                state_next = bpa_pkg::S_FIND_ROW;
                            end
                        end
                        default:
                        begin
                            state_next = bpa_pkg::S_DONE;
                        end
                    endcase
                end
            end
            bpa_pkg::S_RD:
            begin
                rd_en      = 1'b1;
                state_next = bpa_pkg::S_WR;
            end
            bpa_pkg::S_WR:
            begin
                wr_en   = 1'b1;
                wr_data = row_word | range_mask;
                if (row_reg == last_row_reg)
                begin
                    state_next = bpa_pkg::S_DONE;
                end
                else
                begin
                    row_next   = row_reg + 1'b1;
                    state_next = bpa_pkg::S_RD;
                end
            end
            bpa_pkg::S_FIND_ROW:
            begin
                if (ffs_st.done)
                begin
                    row_next   = ffs_st.index;
                    state_next = bpa_pkg::S_ARD;
                end
            end
            bpa_pkg::S_ARD:
            begin
                rd_en      = 1'b1;
                state_next = bpa_pkg::S_ASTART;
            end
            bpa_pkg::S_ASTART:
            begin
                ffs_start  = 1'b1;
                ffs_word   = row_word;
                state_next = bpa_pkg::S_AFIND;
            end
            bpa_pkg::S_AFIND:
            begin
                ffs_word = row_word;
                if (ffs_st.done)
                begin
                    bit_next   = ffs_st.index;
                    state_next = bpa_pkg::S_AWR;
                end
            end
            bpa_pkg::S_AWR:
            begin
                wr_en          = 1'b1;
                wr_data        = row_word & ~bit_mask;
                res_index_next = {row_reg, bit_reg};
                res_found_next = 1'b1;
                state_next     = bpa_pkg::S_DONE;
            end
            bpa_pkg::S_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {3'b000, res_found_reg, res_index_reg};
                    state_next     = bpa_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bpa_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bpa_pkg::S_IDLE;
            reserved_reg  <= '0;
            valid_reg     <= '0;
            summary_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                reserved_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                valid_reg[row_reg]   <= 1'b1;
                summary_reg[row_reg] <= |wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        row_reg       <= row_next;
        last_row_reg  <= last_row_next;
        bit_reg       <= bit_next;
        res_index_reg <= res_index_next;
        res_found_reg <= res_found_next;
        out_data_reg  <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[row_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= bitmap_mem[row_reg];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // scanner reports only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        ffs_st.done |-> (state_reg == bpa_pkg::S_FIND_ROW || state_reg == bpa_pkg::S_AFIND))
        else $error("scanner finished outside a search state");

    // the row chosen for allocation must be flagged as holding a free page
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpa_pkg::S_ASTART |-> (summary_reg[row_reg] && valid_reg[row_reg]))
        else $error("allocation row has no free page");

    // the page handed out must have been free
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bpa_pkg::S_AWR |-> ((row_word & bit_mask) != '0))
        else $error("allocated page was not free");

endmodule

### test/tb_top.sv
// Self-checking testbench for the bitmap page allocator: stimulus, predictor and scoreboard.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int DRAIN_CYCLES = 25;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int LONG_HOLD_AFTER = 160;

    typedef struct packed {
        logic [1:0]                 cmd;
        logic [bpa_pkg::PAGE_W-1:0] first_page;
        logic [bpa_pkg::CNT_W-1:0]  end_page;
    } page_cmd_t;

    typedef struct packed {
        logic [bpa_pkg::PAGE_W-1:0] page_index;
        logic                       found;
    } alloc_result_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic [bpa_pkg::CNT_W-1:0]  cfg_wdata = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [31:0]                s_tdata = '0;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [15:0]                m_tdata;

    // predictor state
    logic [bpa_pkg::NUM_PAGES-1:0] free_pages = '0;
    logic [bpa_pkg::CNT_W-1:0]     reserved_limit = '0;

    page_cmd_t     pending_cmds[$];
    alloc_result_t expected_results[$];
    page_cmd_t     cmd_in_flight;
    int            mismatches = 0;
    int            results_seen = 0;
    bit            quiet = 1'b0;

    bitmap_page_allocator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 clk = ~clk;

    function automatic alloc_result_t apply_command(page_cmd_t c);
        alloc_result_t r;
        int            p;
        int            stop;
        r.page_index = '0;
        r.found      = 1'b0;
        case (c.cmd)
            bpa_pkg::CMD_MARK:
            begin
                stop = (int'(c.end_page) > bpa_pkg::NUM_PAGES) ? bpa_pkg::NUM_PAGES
                                                                : int'(c.end_page);
                for (p = int'(c.first_page); p < stop; p++)
                    if (p >= int'(reserved_limit))
                        free_pages[p] = 1'b1;
            end
            bpa_pkg::CMD_ALLOC:
            begin
                for (p = 0; p < bpa_pkg::NUM_PAGES && !r.found; p++)
                    if (free_pages[p])
                    begin
                        free_pages[p] = 1'b0;
                        r.page_index  = bpa_pkg::PAGE_W'(p);
                        r.found       = 1'b1;
                    end
            end
            bpa_pkg::CMD_FREE:
                free_pages[c.first_page] = 1'b1;
            default: ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // driver: hold the transfer until accepted, insert random gaps
    int gap_left = 0;
    always @(posedge clk or negedge rst_n)
    begin
        bit idle_side;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            gap_left = 0;
        end
        else
        begin
            idle_side = !s_tvalid;
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(apply_command(cmd_in_flight));
                idle_side = 1'b1;
            end
            if (idle_side)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (!quiet && pending_cmds.size() > 0 && $urandom_range(0, 5) == 0)
                begin
                    gap_left = $urandom_range(1, 3) - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_cmds.size() > 0)
                begin
                    cmd_in_flight = pending_cmds.pop_front();
                    s_tdata  <= {5'b0, cmd_in_flight.end_page, cmd_in_flight.first_page,
                                 cmd_in_flight.cmd};
                    s_tvalid <= 1'b1;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure, with one long hold-off once enough results have come
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            hold_left = 0;
        end
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!long_hold_done && results_seen >= LONG_HOLD_AFTER)
        begin
            long_hold_done = 1'b1;
            hold_left = LONG_HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else if (!quiet && $urandom_range(0, 5) == 0)
        begin
            hold_left = $urandom_range(1, 3) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // monitor: compare each result transfer with the oldest prediction
    always @(posedge clk)
    begin
        alloc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", int'(m_tdata), 0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[bpa_pkg::PAGE_W-1:0] !== want.page_index)
                    report_mismatch("page_index", int'(m_tdata[bpa_pkg::PAGE_W-1:0]),
                                    int'(want.page_index));
                if (m_tdata[bpa_pkg::PAGE_W] !== want.found)
                    report_mismatch("found", int'(m_tdata[bpa_pkg::PAGE_W]), int'(want.found));
            end
        end
    end

    task automatic queue_cmd(logic [1:0] cmd, int first_page, int end_page);
        page_cmd_t c;
        c.cmd        = cmd;
        c.first_page = bpa_pkg::PAGE_W'(first_page);
        c.end_page   = bpa_pkg::CNT_W'(end_page);
        pending_cmds.push_back(c);
    endtask

    task automatic queue_random(int count);
        int i;
        int pick;
        int first_page;
        int end_page;
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                queue_cmd(bpa_pkg::CMD_ALLOC, $urandom_range(0, 4095), $urandom_range(0, 8191));
            else if (pick < 65)
            begin
                first_page = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 511);
                queue_cmd(bpa_pkg::CMD_FREE, first_page, $urandom_range(0, 8191));
            end
            else if (pick < 95)
            begin
                first_page = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4095)
                                                         : $urandom_range(0, 511);
                case ($urandom_range(0, 15))
                    0:       end_page = $urandom_range(4096, 8191);
                    1:       end_page = 4096;
                    2, 3:    end_page = $urandom_range(0, first_page);
                    default: end_page = first_page + $urandom_range(1, 96);
                endcase
                // keep wide ranges rare, they walk many rows
                if (end_page > 4096 && $urandom_range(0, 1) == 0)
                    first_page = $urandom_range(3900, 4095);
                queue_cmd(bpa_pkg::CMD_MARK, first_page, end_page);
            end
            else
                queue_cmd(CMD_UNUSED, $urandom_range(0, 4095), $urandom_range(0, 8191));
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (pending_cmds.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reserved(int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= bpa_pkg::CNT_W'(value);
        @(posedge clk);
        cfg_we    <= 1'b0;
        reserved_limit = bpa_pkg::CNT_W'(value);
        @(negedge clk);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        write_reserved(0);
        // directed: empty store, unused code, empty and reversed ranges, store edges
        queue_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        queue_cmd(CMD_UNUSED, 4095, 8191);
        queue_cmd(bpa_pkg::CMD_MARK, 5, 5);
        queue_cmd(bpa_pkg::CMD_MARK, 10, 3);
        queue_cmd(bpa_pkg::CMD_MARK, 4095, 4096);
        queue_cmd(bpa_pkg::CMD_ALLOC, 4095, 8191);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        queue_cmd(bpa_pkg::CMD_FREE, 4095, 0);
        queue_cmd(bpa_pkg::CMD_FREE, 4095, 8191);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0, 4096);
        queue_cmd(bpa_pkg::CMD_MARK, 0, 4096);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        queue_cmd(bpa_pkg::CMD_FREE, 0, 0);
        queue_cmd(bpa_pkg::CMD_ALLOC, 0, 0);
        queue_cmd(bpa_pkg::CMD_MARK, 4000, 8191);
        queue_cmd(bpa_pkg::CMD_MARK, 0, 8191);
        queue_cmd(CMD_UNUSED, 0, 0);
        queue_cmd(bpa_pkg::CMD_FREE, 2048, 4096);
        queue_cmd(bpa_pkg::CMD_ALLOC, 4095, 8191);
        wait_drained();

        write_reserved(37);
        queue_random(100);
        wait_drained();

        write_reserved(4096);
        queue_cmd(bpa_pkg::CMD_MARK, 0, 4096);
        queue_cmd(bpa_pkg::CMD_FREE, 3, 0);
        queue_random(100);
        wait_drained();

        write_reserved(4095);
        queue_cmd(bpa_pkg::CMD_MARK, 4090, 4096);
        queue_cmd(bpa_pkg::CMD_MARK, 0, 8191);
        queue_random(60);
        wait_drained();

        write_reserved($urandom_range(0, 600));
        queue_random(100);
        wait_drained();

        // final stretch without any idling on either side
        write_reserved(0);
        quiet = 1'b1;
        queue_random(100);
        wait_drained();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### files.f
design/bpa_pkg.sv
design/bpa_ffs.sv
design/bitmap_page_allocator_top.sv
test/tb_top.sv
